@@ hw/rtl/ptsa_pkg.sv @@
package ptsa_pkg;

   // Defaults for the top-level parameters
   localparam int NUM_SLOTS_DEF  = 512;
   localparam int SLOT_SHIFT_DEF = 22;

   // Fixed field widths
   localparam int OPCODE_W = 2;
   localparam int ADDR_W   = 31;
   localparam int INDEX_W  = 9;
   localparam int STATUS_W = 2;

   // Bitmap is searched one byte-wide group at a time
   localparam int GRP_W = 8;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOWEST  = 2'd0,
      OP_HIGHEST = 2'd1,
      OP_NAMED   = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_FREE  = 2'd1,
      ST_CONFLICT = 2'd2
   } status_type;

   // Bitmap status handed from the map to the decision logic
   typedef struct packed {
      logic any_free;
      logic named_free;
   } map_flags_type;

   function automatic logic [2:0] lowest8(input logic [GRP_W-1:0] v);
      logic [2:0] r;
      r = '0;
      for (int i = GRP_W - 1; i >= 0; i--) begin
         if (v[i]) r = 3'(i);
      end
      return r;
   endfunction

   function automatic logic [2:0] highest8(input logic [GRP_W-1:0] v);
      logic [2:0] r;
      r = '0;
      for (int i = 0; i < GRP_W; i++) begin
         if (v[i]) r = 3'(i);
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/page_table_slot_allocator_unit.sv @@
// Page-table slot allocator. Keeps a free bitmap of NUM_SLOTS regions, each
// 2**SLOT_SHIFT bytes wide (512 x 4 MiB by default); after reset every slot
// is free except the first and the last, and no clearing pass is needed.
// A request (tuser = opcode) claims the lowest free slot, the highest free
// slot, or the slot holding req_tdata's address; the response gives the slot
// index, its base address and a status in tuser (ok, no free slot, conflict).
// A failed request leaves the bitmap untouched. Slots are never released.
// Rate: one request per cycle sustained while rsp_tready is high. A request
// is registered in the request stage on acceptance, its response when it
// advances; the bitmap search and the one-bit update of the same cycle form
// the loop that the next request depends on. The response register
// decouples the sides: one more request is taken while a response waits.
module page_table_slot_allocator_unit #(
   parameter int NUM_SLOTS  = ptsa_pkg::NUM_SLOTS_DEF,
   parameter int SLOT_SHIFT = ptsa_pkg::SLOT_SHIFT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] request_address, [31] zero
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [8:0] slot_index, [39:9] slot_base
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import ptsa_pkg::*;

   localparam int NUM_GRPS = (NUM_SLOTS + GRP_W - 1) / GRP_W;
   localparam int MAP_IW   = $clog2(NUM_GRPS * GRP_W);

   // Request stage
   logic                s1_valid_ff, s1_valid_in;
   logic [OPCODE_W-1:0] s1_op_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;

   // Response stage
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_idx_ff;
   logic [ADDR_W-1:0]   rsp_base_ff;
   status_type          rsp_status_ff;

   logic                req_xfer, advance;
   logic [31:0]         named;
   logic [MAP_IW-1:0]   low_slot, high_slot;
   map_flags_type       flags;
   logic [ADDR_W-1:0]   slot;
   logic [ADDR_W-1:0]   slot_base;
   status_type          status;
   logic                clr_en;

   // Request moves on when the response register is empty or being drained
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff   <= req_tuser;
         s1_addr_ff <= req_tdata[ADDR_W-1:0];
      end
      if (advance) begin
         rsp_idx_ff    <= slot[INDEX_W-1:0];
         rsp_base_ff   <= slot_base;
         rsp_status_ff <= status;
      end
   end

   // Slot number named by the address
   assign named     = {1'b0, s1_addr_ff} >> SLOT_SHIFT;
   assign slot_base = slot << SLOT_SHIFT;

   ptsa_map #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_map (
      .clock     (clock),
      .reset     (reset),
      .clr_en    (clr_en && advance),
      .clr_idx   (slot[MAP_IW-1:0]),
      .named_idx (named[MAP_IW-1:0]),
      .low_slot  (low_slot),
      .high_slot (high_slot),
      .flags     (flags)
   );

   ptsa_decide #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_decide (
      .opcode    (s1_op_ff),
      .named     (named),
      .flags     (flags),
      .low_slot  (low_slot),
      .high_slot (high_slot),
      .slot      (slot),
      .status    (status),
      .clr_en    (clr_en)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_base_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Every accepted request lands in the request stage
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("accepted request lost");

   // A claim that updates the bitmap is reported as a success
   a_claim_ok: assert property (@(posedge clock) disable iff (reset)
      (advance && clr_en) |=> (rsp_valid_ff && (rsp_status_ff == ST_OK)))
      else $error("bitmap changed without a successful response");

   // A successful response never hands out the reserved first slot
   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      (advance && (status == ST_OK)) |=> (rsp_idx_ff != '0 || rsp_base_ff != '0))
      else $error("first slot handed out");

endmodule

@@ hw/rtl/ptsa_map.sv @@
module ptsa_map #(
   parameter int NUM_SLOTS = ptsa_pkg::NUM_SLOTS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          clr_en,
   input  logic [$clog2(((NUM_SLOTS+7)/8)*8)-1:0]        clr_idx,
   input  logic [$clog2(((NUM_SLOTS+7)/8)*8)-1:0]        named_idx,
   output logic [$clog2(((NUM_SLOTS+7)/8)*8)-1:0]        low_slot,
   output logic [$clog2(((NUM_SLOTS+7)/8)*8)-1:0]        high_slot,
   output ptsa_pkg::map_flags_type                       flags
);
   import ptsa_pkg::*;

   localparam int NUM_GRPS = (NUM_SLOTS + GRP_W - 1) / GRP_W;
   localparam int MAP_W    = NUM_GRPS * GRP_W;
   localparam int GRP_IW   = $clog2(NUM_GRPS);

   logic [MAP_W-1:0]    map_ff, map_in, map_rst;
   logic [NUM_GRPS-1:0] grp_any;
   logic [GRP_IW-1:0]   low_g, high_g;
   logic [GRP_W-1:0]    low_byte, high_byte;

   // Free at reset: everything but the first and last slot; padding stays taken
   always_comb begin
      for (int i = 0; i < MAP_W; i++) begin
         map_rst[i] = (i != 0) && (i < NUM_SLOTS - 1);
      end
   end

   always_comb begin
      map_in = map_ff;
      if (clr_en) map_in[clr_idx] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= map_rst;
      end else begin
         map_ff <= map_in;
      end
   end

   // Two-level search: group OR, group priority, then bit priority in the byte
   always_comb begin
      for (int g = 0; g < NUM_GRPS; g++) begin
         grp_any[g] = |map_ff[g*GRP_W +: GRP_W];
      end
   end

   always_comb begin
      low_g  = '0;
      high_g = '0;
      for (int g = NUM_GRPS - 1; g >= 0; g--) begin
         if (grp_any[g]) low_g = GRP_IW'(g);
      end
      for (int g = 0; g < NUM_GRPS; g++) begin
         if (grp_any[g]) high_g = GRP_IW'(g);
      end
   end

   assign low_byte  = map_ff[{low_g, 3'b000} +: GRP_W];
   assign high_byte = map_ff[{high_g, 3'b000} +: GRP_W];
   assign low_slot  = {low_g, lowest8(low_byte)};
   assign high_slot = {high_g, highest8(high_byte)};

   assign flags = '{any_free:   |grp_any,
                    named_free: (32'(named_idx) < 32'(MAP_W)) ? map_ff[named_idx] : 1'b0};

   // Claimed slot reads taken on the next cycle
   a_clear_sticks: assert property (@(posedge clock) disable iff (reset)
      clr_en |=> !map_ff[$past(clr_idx)])
      else $error("claimed slot still free");

   // Slots are only ever claimed, never freed
   a_no_release: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((map_ff & ~$past(map_ff)) == '0))
      else $error("slot went from taken to free");

endmodule

@@ hw/rtl/ptsa_decide.sv @@
module ptsa_decide #(
   parameter int NUM_SLOTS = ptsa_pkg::NUM_SLOTS_DEF
) (
   input  logic [ptsa_pkg::OPCODE_W-1:0]               opcode,
   input  logic [31:0]                                 named,
   input  ptsa_pkg::map_flags_type                     flags,
   input  logic [$clog2(((NUM_SLOTS+7)/8)*8)-1:0]      low_slot,
   input  logic [$clog2(((NUM_SLOTS+7)/8)*8)-1:0]      high_slot,
   output logic [ptsa_pkg::ADDR_W-1:0]                 slot,
   output ptsa_pkg::status_type                        status,
   output logic                                        clr_en
);
   import ptsa_pkg::*;

   logic oor;

   assign oor = named >= 32'(NUM_SLOTS);

   always_comb begin
      slot   = '0;
      status = ST_NO_FREE;
      clr_en = 1'b0;
      case (opcode_type'(opcode))
         OP_LOWEST: begin
            if (flags.any_free && (low_slot != '0)) begin
               slot   = ADDR_W'(low_slot);
               status = ST_OK;
               clr_en = 1'b1;
            end
         end
         OP_HIGHEST: begin
            if (flags.any_free && (high_slot != '0)) begin
               slot   = ADDR_W'(high_slot);
               status = ST_OK;
               clr_en = 1'b1;
            end
         end
         OP_NAMED: begin
            if (oor) begin
               slot   = ADDR_W'(named[INDEX_W-1:0]);
               status = ST_CONFLICT;
            end else if (!flags.named_free) begin
               slot   = ADDR_W'(named);
               status = ST_CONFLICT;
            end else if (named != '0) begin
               slot   = ADDR_W'(named);
               status = ST_OK;
               clr_en = 1'b1;
            end
         end
         default: begin
            slot   = '0;
            status = ST_NO_FREE;
         end
      endcase
   end

endmodule
